### rtl/rmt_pkg.sv
// Shared types and constants for the signal-strength median/EWMA/MAD tracker.
// Used by the top level, the rank unit and the divider; no dependencies of its own.
`timescale 1ns / 1ps

package rmt_pkg;

	localparam logic signed [15:0] LEVEL_RESET  = 16'sh CE00;  // -50.0 in Q8.8
	localparam logic        [8:0]  WEIGHT_RESET = 9'd77;
	localparam logic        [8:0]  WEIGHT_ONE   = 9'd256;
	localparam logic        [15:0] SCORE_ONE    = 16'h8000;
	localparam logic        [7:0]  SIGN_FLIP    = 8'h80;
	localparam logic               REG_WEIGHT   = 1'b0;

	typedef enum logic [3:0] {
		S_IDLE,
		S_EWMA_MUL,
		S_EWMA_ADD,
		S_SWEEP,
		S_DRAIN,
		S_DECIDE,
		S_NEXT_PASS,
		S_DIV_START,
		S_DIV_WAIT,
		S_FINISH
	} seq_state_t;

	// Controls for the shared rank-select unit.
	typedef struct packed {
		logic start;      // begin a new selection
		logic acc;        // read data of one entry is present
		logic decide;     // settle the current bit
		logic latch_med;  // keep the finished result as the window median
		logic mode;       // 0: raw samples, 1: absolute deviations
	} rank_ctrl_t;

endpackage

### rtl/rssi_median_ewma_mad_tracker_core.sv
// Top level of the signal-strength tracker: window, sequencer, EWMA and score path.
// Depends on rmt_pkg, rmt_window, rmt_rank_unit and rmt_divider.
//
// Usage: one signed 8-bit sample enters per word on the input channel (in_valid,
// in_ready); one result word leaves on the output channel (out_valid, out_ready)
// with the score, the updated Q8.8 level, the filtered sample and the warm flag.
// The weight register sits at byte address 0 of the APB port and can be read back.
// in_ready is high only while the sequencer is idle, so one word is worked on
// at a time. Until three samples are held a word goes from the EWMA straight to
// the output register. After that the shared rank-select unit sweeps the n held
// samples through the window's single read port once per result bit, twice
// (median, then MAD), and then the divider forms the score.
// The result sits in an output register; a new word is accepted while it waits.
// If the receiver stalls longer, the sequencer holds the next result until the
// register frees. Reset empties the window, sets the level to -50.0 dBm and the
// weight to 77/256; the window memory itself is not cleared, since only written
// entries are ever read.
`timescale 1ns / 1ps

module rssi_median_ewma_mad_tracker_core #(
	parameter int WINDOW_DEPTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [7:0]  rssi_sample,
	output logic               out_valid,
	input  logic               out_ready,
	output logic        [15:0] stability_score,
	output logic signed [15:0] smoothed_level_out,
	output logic signed [7:0]  filtered_sample,
	output logic               window_warm,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic        [2:0]  paddr,
	input  logic        [31:0] pwdata,
	output logic        [31:0] prdata,
	output logic               pready
);
	import rmt_pkg::*;

	localparam int AW = $clog2(WINDOW_DEPTH);
	localparam int CW = $clog2(WINDOW_DEPTH + 1);

	seq_state_t state_q, state_nxt;
	rank_ctrl_t rctrl;

	logic [8:0]          weight_q;
	logic [8:0]          wr_val;
	logic signed [15:0]  level_q;
	logic [AW-1:0]       wptr_q;
	logic [CW-1:0]       fill_q;
	logic [CW-1:0]       fill_nxt;
	logic signed [7:0]   h0_q, h1_q;
	logic signed [7:0]   filt_q;
	logic                warm_q;
	logic signed [7:0]   med3;
	logic signed [7:0]   lo_ab, hi_ab, lo_hc;
	logic signed [27:0]  prod_q;
	logic signed [17:0]  ediff;
	logic signed [27:0]  num;
	logic signed [19:0]  lvl_wide;
	logic signed [15:0]  lvl_sat;
	logic                pass_q;
	logic [AW-1:0]       idx_q;
	logic                rd_valid_s1;
	logic                idx_last;
	logic                accept;
	logic                load_out;
	logic [7:0]          rd_data;
	logic [7:0]          rank_res;
	logic                rank_last;
	logic [7:0]          mad;
	logic [8:0]          divisor;
	logic                div_start;
	logic                div_done;
	logic [15:0]         quot;
	logic                out_valid_q;
	logic [15:0]         score_q;
	logic signed [15:0]  lvl_out_q;
	logic signed [7:0]   filt_out_q;
	logic                warm_out_q;

	// Configuration port.
	assign pready = 1'b1;
	assign prdata = {23'd0, weight_q};
	assign wr_val = (pwdata[8:0] > WEIGHT_ONE) ? WEIGHT_ONE : pwdata[8:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weight_q <= WEIGHT_RESET;
		end else if (psel && penable && pwrite && pready && (paddr[2] == REG_WEIGHT)) begin
			weight_q <= wr_val;
		end
	end

	// Intake: window write, pointers and the three-point median.
	assign accept   = in_valid && in_ready;
	assign fill_nxt = (fill_q == CW'(WINDOW_DEPTH)) ? fill_q : CW'(fill_q + 1'b1);

	always_comb begin
		lo_ab = (rssi_sample < h0_q) ? rssi_sample : h0_q;
		hi_ab = (rssi_sample < h0_q) ? h0_q : rssi_sample;
		lo_hc = (hi_ab < h1_q) ? hi_ab : h1_q;
		med3  = (lo_ab > lo_hc) ? lo_ab : lo_hc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			fill_q <= '0;
		end else if (accept) begin
			wptr_q <= (wptr_q == AW'(WINDOW_DEPTH - 1)) ? '0 : AW'(wptr_q + 1'b1);
			fill_q <= fill_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			h0_q   <= rssi_sample;
			h1_q   <= h0_q;
			warm_q <= (fill_q >= CW'(2));
			filt_q <= (fill_q >= CW'(2)) ? med3 : rssi_sample;
		end
	end

	// EWMA as L + w*(256*f - L)/256, one multiply then one add and round.
	assign ediff    = 18'($signed({filt_q, 8'd0})) - 18'(level_q);
	assign num      = 28'($signed({level_q, 8'd0})) + prod_q + 28'sd128;
	assign lvl_wide = num[27:8];

	always_comb begin
		if (lvl_wide > 20'sd32767) begin
			lvl_sat = 16'sh7FFF;
		end else if (lvl_wide < -20'sd32768) begin
			lvl_sat = 16'sh8000;
		end else begin
			lvl_sat = lvl_wide[15:0];
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_EWMA_MUL) begin
			prod_q <= 28'($signed({1'b0, weight_q})) * 28'(ediff);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= LEVEL_RESET;
		end else if (state_q == S_EWMA_ADD) begin
			level_q <= lvl_sat;
		end
	end

	// Sequencer.
	assign idx_last = (CW'(idx_q) == CW'(fill_q - 1'b1));
	assign load_out = (state_q == S_FINISH) && (!out_valid_q || out_ready);

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE:      if (in_valid) state_nxt = S_EWMA_MUL;
			S_EWMA_MUL:  state_nxt = S_EWMA_ADD;
			S_EWMA_ADD:  state_nxt = warm_q ? S_SWEEP : S_FINISH;
			S_SWEEP:     if (idx_last) state_nxt = S_DRAIN;
			S_DRAIN:     state_nxt = S_DECIDE;
			S_DECIDE: begin
				if (!rank_last) begin
					state_nxt = S_SWEEP;
				end else begin
					state_nxt = pass_q ? S_DIV_START : S_NEXT_PASS;
				end
			end
			S_NEXT_PASS: state_nxt = S_SWEEP;
			S_DIV_START: state_nxt = S_DIV_WAIT;
			S_DIV_WAIT:  if (div_done) state_nxt = S_FINISH;
			S_FINISH:    if (!out_valid_q || out_ready) state_nxt = S_IDLE;
			default:     state_nxt = S_IDLE;
		endcase
	end

	always_comb begin
		in_ready        = 1'b0;
		rctrl.start     = 1'b0;
		rctrl.decide    = 1'b0;
		rctrl.latch_med = 1'b0;
		rctrl.acc       = rd_valid_s1;
		rctrl.mode      = pass_q;
		div_start       = 1'b0;
		unique case (state_q)
			S_IDLE:      in_ready = 1'b1;
			S_EWMA_ADD:  rctrl.start = warm_q;
			S_DECIDE:    rctrl.decide = 1'b1;
			S_NEXT_PASS: begin
				rctrl.start     = 1'b1;
				rctrl.latch_med = 1'b1;
			end
			S_DIV_START: div_start = 1'b1;
			default:     ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pass_q      <= 1'b0;
			idx_q       <= '0;
			rd_valid_s1 <= 1'b0;
		end else begin
			state_q     <= state_nxt;
			rd_valid_s1 <= (state_q == S_SWEEP);
			idx_q       <= (state_q == S_SWEEP) ? AW'(idx_q + 1'b1) : '0;
			if (state_q == S_EWMA_ADD) begin
				pass_q <= 1'b0;
			end else if (state_q == S_NEXT_PASS) begin
				pass_q <= 1'b1;
			end
		end
	end

	rmt_window #(
		.DEPTH (WINDOW_DEPTH),
		.AW    (AW)
	) u_window (
		.clk     (clk),
		.wr_en   (accept),
		.wr_addr (wptr_q),
		.wr_data (rssi_sample),
		.rd_addr (idx_q),
		.rd_data (rd_data)
	);

	rmt_rank_unit #(
		.CW (CW)
	) u_rank (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (rctrl),
		.rd_data  (rd_data),
		.k_init   (fill_q >> 1),
		.result   (rank_res),
		.last_bit (rank_last)
	);

	// MAD is floored at one before it becomes the divisor 1 + MAD.
	assign mad     = (rank_res == 8'd0) ? 8'd1 : rank_res;
	assign divisor = {1'b0, mad} + 9'd1;

	rmt_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.divisor  (divisor),
		.quotient (quot),
		.done     (div_done)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			score_q    <= warm_q ? quot : SCORE_ONE;
			lvl_out_q  <= level_q;
			filt_out_q <= filt_q;
			warm_out_q <= warm_q;
		end
	end

	assign out_valid          = out_valid_q;
	assign stability_score    = score_q;
	assign smoothed_level_out = lvl_out_q;
	assign filtered_sample    = filt_out_q;
	assign window_warm        = warm_out_q;

endmodule

### rtl/rmt_window.sv
// Sample window memory: one write port and one registered read port.
// Depends on nothing but the clock.
`timescale 1ns / 1ps

module rmt_window #(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [7:0]    wr_data,
	input  logic [AW-1:0] rd_addr,
	output logic [7:0]    rd_data
);
	logic [7:0] mem [DEPTH];
	logic [7:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

### rtl/rmt_rank_unit.sv
// Shared rank-select unit: finds the k-th smallest of a swept set, one bit per pass.
// Uses rmt_pkg for its control struct.
`timescale 1ns / 1ps

module rmt_rank_unit #(
	parameter int CW = 5
) (
	input  logic                clk,
	input  logic                arst_n,
	input  rmt_pkg::rank_ctrl_t ctrl,
	input  logic [7:0]          rd_data,
	input  logic [CW-1:0]       k_init,
	output logic [7:0]          result,
	output logic                last_bit
);
	import rmt_pkg::*;

	logic [7:0]          prefix_q;
	logic [7:0]          mask_q;
	logic [7:0]          bitsel_q;
	logic [CW-1:0]       k_q;
	logic [CW-1:0]       cnt_q;
	logic signed [7:0]   med_q;
	logic signed [8:0]   diff;
	logic [8:0]          adiff;
	logic [7:0]          ele;
	logic                hit;

	// Samples are compared in offset-binary form so that unsigned order matches.
	always_comb begin
		diff  = $signed({rd_data[7], rd_data}) - $signed({med_q[7], med_q});
		adiff = diff[8] ? 9'(-diff) : diff;
		ele   = ctrl.mode ? adiff[7:0] : (rd_data ^ SIGN_FLIP);
		hit   = ((ele & bitsel_q) == 8'd0) && (((ele ^ prefix_q) & mask_q) == 8'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prefix_q <= '0;
			mask_q   <= '0;
			bitsel_q <= 8'h80;
			k_q      <= '0;
			cnt_q    <= '0;
			med_q    <= '0;
		end else begin
			if (ctrl.latch_med) begin
				med_q <= $signed(prefix_q ^ SIGN_FLIP);
			end
			if (ctrl.start) begin
				prefix_q <= '0;
				mask_q   <= '0;
				bitsel_q <= 8'h80;
				k_q      <= k_init;
				cnt_q    <= '0;
			end else if (ctrl.decide) begin
				// Fewer than k+1 candidates below with a zero here means this bit is one.
				if (!(k_q < cnt_q)) begin
					prefix_q <= prefix_q | bitsel_q;
					k_q      <= k_q - cnt_q;
				end
				mask_q   <= mask_q | bitsel_q;
				bitsel_q <= bitsel_q >> 1;
				cnt_q    <= '0;
			end else if (ctrl.acc && hit) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	assign result   = prefix_q;
	assign last_bit = bitsel_q[0];

endmodule

### rtl/rmt_divider.sv
// Restoring divider for the score: 32768 divided by a 9-bit divisor, one bit a cycle.
// Uses the score constant from rmt_pkg.
`timescale 1ns / 1ps

module rmt_divider (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [8:0]  divisor,
	output logic [15:0] quotient,
	output logic        done
);
	import rmt_pkg::*;

	logic [8:0]  div_q;
	logic [8:0]  rem_q;
	logic [15:0] quot_q;
	logic [3:0]  cnt_q;
	logic        busy_q;
	logic [9:0]  trial;
	logic        ge;

	always_comb begin
		trial = {rem_q, SCORE_ONE[cnt_q]};
		ge    = trial >= {1'b0, div_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= 4'd15;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == 4'd0) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			div_q  <= divisor;
			rem_q  <= '0;
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q  <= ge ? 9'(trial - {1'b0, div_q}) : trial[8:0];
			quot_q <= {quot_q[14:0], ge};
		end
	end

	assign quotient = quot_q;
	assign done     = busy_q && (cnt_q == 4'd0);

endmodule

### rtl/rmt_checker.sv
// Port-level checks for the tracker, bound to the top level.
// Sees only the top-level ports; no package needed.
`timescale 1ns / 1ps

module rmt_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input logic       [15:0] stability_score,
	input logic signed [15:0] smoothed_level_out,
	input logic              window_warm
);

	// A stalled result word holds its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(stability_score)
			&& $stable(smoothed_level_out) && $stable(window_warm))
		else $error("result word changed while stalled");

	// Taking a word makes the block busy, so in_ready falls straight after an accept.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken again right after an accept");

	// A cold window always reports the full score.
	a_cold_score: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !window_warm |-> stability_score == 16'h8000)
		else $error("cold window score is not 1.0");

	// With MAD between 1 and 255, the score lies between 128 and 16384.
	a_warm_score: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && window_warm |-> stability_score <= 16'd16384
			&& stability_score >= 16'd128)
		else $error("warm score out of range");

endmodule

bind rssi_median_ewma_mad_tracker_core rmt_checker u_rmt_checker (.*);
